[design/dc2c_pkg.sv]
// Shared constants, tables, payload types and divisor helpers for the day-count calendar block.
package dc2c_pkg;

  localparam int DAY_COUNT_BITS_DEF = 16;

  // Field widths
  localparam int MS_BITS    = 27;
  localparam int YEAR_BITS  = 12;
  localparam int DOY_BITS   = 9;
  localparam int MONTH_BITS = 4;
  localparam int DOM_BITS   = 5;
  localparam int HOUR_BITS  = 5;
  localparam int MIN_BITS   = 6;
  localparam int SEC_BITS   = 6;
  localparam int MSEC_BITS  = 10;

  // Time of day
  localparam logic [MS_BITS-1:0] MS_DAY_MAX = 27'd86399999;
  localparam int MS_PER_HOUR = 1000 * 60 * 60;
  localparam int MS_PER_MIN  = 1000 * 60;
  localparam int MS_PER_SEC  = 1000;
  localparam int HOUR_STEPS  = HOUR_BITS;
  localparam int MIN_STEPS   = MIN_BITS;
  localparam int SEC_STEPS   = SEC_BITS;
  localparam int TIME_STEPS  = HOUR_STEPS + MIN_STEPS + SEC_STEPS;

  // Register stages from input transfer to output register
  localparam int PIPE_DEPTH = TIME_STEPS + 1;

  // Calendar: day numbers are rebased onto 1601-01-01, start of a 400-year cycle
  localparam int EPOCH_OFFSET    = 130391;
  localparam int BASE_YEAR_CYCLE = 1601;
  localparam int DAYS_400        = 146097;
  localparam int DAYS_100        = 36524;
  localparam int DAYS_4          = 1461;
  localparam int DAYS_1          = 365;
  localparam int YEARS_400       = 400;
  localparam int YEARS_100       = 100;
  localparam int LAST_QUAD       = 24;  // index of the 4-year group that ends a century
  localparam int LAST_YEAR       = 3;   // index of the year that ends a group or cycle
  localparam int MONTHS          = 12;

  localparam logic [DOY_BITS-1:0] CUM_COMMON [13] =
    '{9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181,
      9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd365};
  localparam logic [DOY_BITS-1:0] CUM_LEAP [13] =
    '{9'd0, 9'd31, 9'd60, 9'd91, 9'd121, 9'd152, 9'd183,
      9'd213, 9'd244, 9'd274, 9'd305, 9'd335, 9'd366};

  typedef struct packed {
    logic [YEAR_BITS-1:0]  year;
    logic [DOY_BITS-1:0]   day_of_year;
    logic [MONTH_BITS-1:0] month;
    logic [DOM_BITS-1:0]   day_of_month;
  } date_t;

  typedef struct packed {
    logic [HOUR_BITS-1:0] hour;
    logic [MIN_BITS-1:0]  minute;
    logic [SEC_BITS-1:0]  second;
    logic [MSEC_BITS-1:0] millisecond;
  } tod_t;

  // Days in the first m months, i.e. before the first day of month m+1 (m = 0..12)
  function automatic logic [DOY_BITS-1:0] cum_days(input logic leap,
                                                   input logic [MONTH_BITS-1:0] m);
    logic [DOY_BITS-1:0] v;
    v = '0;
    if (m <= MONTH_BITS'(MONTHS)) begin
      v = leap ? CUM_LEAP[m] : CUM_COMMON[m];
    end
    return v;
  endfunction

  // Divisor of time step k: hours, then minutes, then seconds, MSB first
  function automatic logic [MS_BITS-1:0] time_divisor(input int k);
    int d;
    if (k < HOUR_STEPS) begin
      d = MS_PER_HOUR << (HOUR_STEPS - 1 - k);
    end else if (k < HOUR_STEPS + MIN_STEPS) begin
      d = MS_PER_MIN << (HOUR_STEPS + MIN_STEPS - 1 - k);
    end else begin
      d = MS_PER_SEC << (TIME_STEPS - 1 - k);
    end
    return MS_BITS'(d);
  endfunction

  // Divisor of date step j: 400-year cycles, centuries, 4-year groups, years
  function automatic int date_divisor(input int j, input int q400);
    int d;
    if (j < q400) begin
      d = DAYS_400 << (q400 - 1 - j);
    end else if (j < q400 + 2) begin
      d = DAYS_100 << (q400 + 1 - j);
    end else if (j < q400 + 7) begin
      d = DAYS_4 << (q400 + 6 - j);
    end else begin
      d = DAYS_1 << (q400 + 8 - j);
    end
    return d;
  endfunction

endpackage

[design/dc2c_date_pipe.sv]
// Date pipeline: day count to year, day of year, month and day of month.
module dc2c_date_pipe #(
  parameter int DAY_COUNT_BITS = dc2c_pkg::DAY_COUNT_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      en,
  input  logic [DAY_COUNT_BITS-1:0] day_count,
  output dc2c_pkg::date_t           date
);

  localparam int DMAX  = (1 << DAY_COUNT_BITS) - 1 + dc2c_pkg::EPOCH_OFFSET;
  localparam int DW    = $clog2(DMAX + 1);
  localparam int Q400  = $clog2(DMAX / dc2c_pkg::DAYS_400 + 1);
  localparam int NS    = Q400 + 9;
  localparam int EXTRA = dc2c_pkg::PIPE_DEPTH - (NS + 3);
  localparam int YB    = dc2c_pkg::YEAR_BITS;
  localparam int DB    = dc2c_pkg::DOY_BITS;
  localparam int MB    = dc2c_pkg::MONTH_BITS;

  logic [DW-1:0] rem [NS+1];
  logic [NS-1:0] quo [NS+1];

  // rebase onto the 400-year cycle
  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= DW'(day_count) + DW'(dc2c_pkg::EPOCH_OFFSET);
      quo[0] <= '0;
    end
  end

  // one restoring compare-subtract per stage
  for (genvar j = 0; j < NS; j++) begin : g_step
    localparam logic [DW-1:0] DIV = DW'(dc2c_pkg::date_divisor(j, Q400));
    logic ge;
    assign ge = (rem[j] >= DIV);
    always_ff @(posedge clk) begin
      if (en) begin
        rem[j+1] <= ge ? (rem[j] - DIV) : rem[j];
        quo[j+1] <= quo[j] | (NS'(ge) << (NS - 1 - j));
      end
    end
  end

  logic [Q400-1:0] n400;
  logic [1:0]      n100;
  logic [4:0]      n4;
  logic [1:0]      n1;
  logic [DB-1:0]   rem_d;
  logic            leap;
  logic [YB-1:0]   year_c;
  logic [MB-1:0]   month_c;

  assign n400  = quo[NS][NS-1:9];
  assign n100  = quo[NS][8:7];
  assign n4    = quo[NS][6:2];
  assign n1    = quo[NS][1:0];
  assign rem_d = rem[NS][DB-1:0];
  assign leap  = (n1 == 2'(dc2c_pkg::LAST_YEAR)) &&
                 ((n4 != 5'(dc2c_pkg::LAST_QUAD)) || (n100 == 2'(dc2c_pkg::LAST_YEAR)));
  // year kept modulo 2^12, as the field is
  assign year_c = YB'(dc2c_pkg::BASE_YEAR_CYCLE)
                + YB'(n400) * YB'(dc2c_pkg::YEARS_400)
                + YB'(n100) * YB'(dc2c_pkg::YEARS_100)
                + YB'({n4, 2'b00})
                + YB'(n1);

  always_comb begin
    month_c = MB'(dc2c_pkg::MONTHS);
    for (int m = dc2c_pkg::MONTHS; m >= 1; m--) begin
      if (rem_d < dc2c_pkg::cum_days(leap, MB'(m))) begin
        month_c = MB'(m);
      end
    end
  end

  logic [YB-1:0] year_r;
  logic [DB-1:0] doy_r;
  logic [MB-1:0] month_r;
  logic          leap_r;

  always_ff @(posedge clk) begin
    if (en) begin
      year_r  <= year_c;
      doy_r   <= rem_d + DB'(1);
      month_r <= month_c;
      leap_r  <= leap;
    end
  end

  logic [DB-1:0]   dom_full;
  dc2c_pkg::date_t dly [EXTRA+1];

  assign dom_full = doy_r - dc2c_pkg::cum_days(leap_r, month_r - MB'(1));

  always_ff @(posedge clk) begin
    if (en) begin
      dly[0].year         <= year_r;
      dly[0].day_of_year  <= doy_r;
      dly[0].month        <= month_r;
      dly[0].day_of_month <= dom_full[dc2c_pkg::DOM_BITS-1:0];
    end
  end

  // align with the time-of-day pipeline
  for (genvar k = 1; k <= EXTRA; k++) begin : g_pad
    always_ff @(posedge clk) begin
      if (en) begin
        dly[k] <= dly[k-1];
      end
    end
  end

  assign date = dly[EXTRA];

endmodule

[design/dc2c_tod_pipe.sv]
// Time-of-day pipeline: milliseconds of day to hour, minute, second and millisecond.
module dc2c_tod_pipe (
  input  logic                          clk,
  input  logic                          en,
  input  logic [dc2c_pkg::MS_BITS-1:0]  ms_of_day,
  output dc2c_pkg::tod_t                tod
);

  localparam int NS = dc2c_pkg::TIME_STEPS;
  localparam int W  = dc2c_pkg::MS_BITS;

  logic [W-1:0]  rem [NS+1];
  logic [NS-1:0] quo [NS+1];

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= (ms_of_day > dc2c_pkg::MS_DAY_MAX) ? dc2c_pkg::MS_DAY_MAX : ms_of_day;
      quo[0] <= '0;
    end
  end

  for (genvar k = 0; k < NS; k++) begin : g_step
    localparam logic [W-1:0] DIV = dc2c_pkg::time_divisor(k);
    logic ge;
    assign ge = (rem[k] >= DIV);
    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1] <= ge ? (rem[k] - DIV) : rem[k];
        quo[k+1] <= quo[k] | (NS'(ge) << (NS - 1 - k));
      end
    end
  end

  assign tod.hour        = quo[NS][NS-1 -: dc2c_pkg::HOUR_BITS];
  assign tod.minute      = quo[NS][dc2c_pkg::MIN_STEPS + dc2c_pkg::SEC_STEPS - 1 -:
                                   dc2c_pkg::MIN_BITS];
  assign tod.second      = quo[NS][dc2c_pkg::SEC_BITS-1:0];
  assign tod.millisecond = rem[NS][dc2c_pkg::MSEC_BITS-1:0];

endmodule

[design/day_count_to_calendar.sv]
// Top level: day count and millisecond of day to Gregorian date and time of day.
//
// Usage:
//   Input channel (in_valid / in_stall, payload day_count, ms_of_day) takes one
//   timestamp per transfer; output channel (out_valid / out_stall) returns one
//   calendar result per input, in order. Items are independent.
//   Throughput: one item per cycle while out_stall does not hold the pipe.
//   The depth is set by the time-of-day split, 17 restoring compare-subtract
//   steps (5 hour, 6 minute, 6 second bits), one per register stage after the
//   saturation stage; the date path (400/100/4/1 year decomposition plus month
//   lookup) runs alongside and is padded to match.
//   A millisecond value past the end of the day saturates to 23:59:59.999.
//   Stall: when out_stall is high with a result waiting, the whole pipeline
//   holds and in_stall goes high in the same cycle; nothing is dropped.
//   Reset (rst, synchronous) clears only the stage valid bits; the pipe comes
//   out empty and accepts input on the next cycle.
module day_count_to_calendar #(
  parameter int DAY_COUNT_BITS = dc2c_pkg::DAY_COUNT_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [DAY_COUNT_BITS-1:0]        day_count,
  input  logic [dc2c_pkg::MS_BITS-1:0]     ms_of_day,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [dc2c_pkg::YEAR_BITS-1:0]   year,
  output logic [dc2c_pkg::DOY_BITS-1:0]    day_of_year,
  output logic [dc2c_pkg::MONTH_BITS-1:0]  month,
  output logic [dc2c_pkg::DOM_BITS-1:0]    day_of_month,
  output logic [dc2c_pkg::HOUR_BITS-1:0]   hour,
  output logic [dc2c_pkg::MIN_BITS-1:0]    minute,
  output logic [dc2c_pkg::SEC_BITS-1:0]    second,
  output logic [dc2c_pkg::MSEC_BITS-1:0]   millisecond
);

  localparam int DEPTH = dc2c_pkg::PIPE_DEPTH;

  logic [DEPTH-1:0] vld;
  logic             en;
  dc2c_pkg::date_t  date;
  dc2c_pkg::tod_t   tod;

  // whole pipe advances unless the finished result is held by the receiver
  assign en       = !vld[DEPTH-1] || !out_stall;
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[DEPTH-2:0], in_valid};
    end
  end

  dc2c_date_pipe #(
    .DAY_COUNT_BITS(DAY_COUNT_BITS)
  ) u_date (
    .clk      (clk),
    .en       (en),
    .day_count(day_count),
    .date     (date)
  );

  dc2c_tod_pipe u_tod (
    .clk      (clk),
    .en       (en),
    .ms_of_day(ms_of_day),
    .tod      (tod)
  );

  assign out_valid    = vld[DEPTH-1];
  assign year         = date.year;
  assign day_of_year  = date.day_of_year;
  assign month        = date.month;
  assign day_of_month = date.day_of_month;
  assign hour         = tod.hour;
  assign minute       = tod.minute;
  assign second       = tod.second;
  assign millisecond  = tod.millisecond;

  a_date_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (month >= 4'd1 && month <= 4'd12 && day_of_month >= 5'd1 &&
                   day_of_year >= 9'd1 && day_of_year <= 9'd366))
    else $error("calendar field out of range");

  a_tod_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (hour <= 5'd23 && minute <= 6'd59 && second <= 6'd59 &&
                   millisecond <= 10'd999))
    else $error("time-of-day field out of range");

  a_doy_vs_dom: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (day_of_year >= 9'(day_of_month)))
    else $error("day of month exceeds day of year");

  a_last_leap_day: assert property (@(posedge clk) disable iff (rst)
    (out_valid && day_of_year == 9'd366) |-> (month == 4'd12 && day_of_month == 5'd31))
    else $error("day 366 is not December 31");

endmodule

[bench/day_count_to_calendar_tb.sv]
// Self-checking bench for the day-count to Gregorian date and time-of-day pipeline.
`timescale 1ns / 1ps

module day_count_to_calendar_tb;

  localparam int DC_BITS    = dc2c_pkg::DAY_COUNT_BITS_DEF;
  localparam int MS_BITS    = dc2c_pkg::MS_BITS;
  localparam int YEAR_BITS  = dc2c_pkg::YEAR_BITS;
  localparam int DOY_BITS   = dc2c_pkg::DOY_BITS;
  localparam int MONTH_BITS = dc2c_pkg::MONTH_BITS;
  localparam int DOM_BITS   = dc2c_pkg::DOM_BITS;
  localparam int HOUR_BITS  = dc2c_pkg::HOUR_BITS;
  localparam int MIN_BITS   = dc2c_pkg::MIN_BITS;
  localparam int SEC_BITS   = dc2c_pkg::SEC_BITS;
  localparam int MSEC_BITS  = dc2c_pkg::MSEC_BITS;
  localparam int EPOCH_YR  = 1958;
  localparam int LAST_MS   = 86399999;
  localparam int HOUR_MS   = 1000 * 60 * 60;
  localparam int MINUTE_MS = 1000 * 60;
  localparam int SECOND_MS = 1000;
  localparam int GAP_MAX   = 18;
  localparam int RAND_ITEMS = 1200;
  localparam int TAIL_CYCLES = 40;  // pipe is 18 deep; some slack past the drain
  localparam int PLAN_ROWS = 22;

  // Days before the first of each month, common and leap years
  localparam int MONTH_START_COMMON [13] =
    '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334, 365};
  localparam int MONTH_START_LEAP [13] =
    '{0, 31, 60, 91, 121, 152, 183, 213, 244, 274, 305, 335, 366};

  typedef struct packed {
    dc2c_pkg::date_t date;
    dc2c_pkg::tod_t  tod;
  } stamp_t;

  // One row of the directed plan; fixed marks rows whose answer is typed in
  typedef struct packed {
    logic [DC_BITS-1:0] day;
    logic [MS_BITS-1:0] ms;
    logic               fixed;
    stamp_t             want;
  } plan_row_t;

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [DC_BITS-1:0]    day_count = '0;
  logic [MS_BITS-1:0]    ms_of_day = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [YEAR_BITS-1:0]  year;
  logic [DOY_BITS-1:0]   day_of_year;
  logic [MONTH_BITS-1:0] month;
  logic [DOM_BITS-1:0]   day_of_month;
  logic [HOUR_BITS-1:0]  hour;
  logic [MIN_BITS-1:0]   minute;
  logic [SEC_BITS-1:0]   second;
  logic [MSEC_BITS-1:0]  millisecond;

  stamp_t    pending_stamps [$];   // calendar results still owed by the pipe, oldest first
  plan_row_t plan [PLAN_ROWS];
  int        mismatches = 0;
  bit        tx_steady = 1'b0;     // sender runs back to back when set
  bit        rx_steady = 1'b0;     // receiver never stalls when set

  day_count_to_calendar #(
    .DAY_COUNT_BITS(DC_BITS)
  ) i_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .day_count   (day_count),
    .ms_of_day   (ms_of_day),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .year        (year),
    .day_of_year (day_of_year),
    .month       (month),
    .day_of_month(day_of_month),
    .hour        (hour),
    .minute      (minute),
    .second      (second),
    .millisecond (millisecond)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Watchdog: worst case is roughly 1250 items, each with a GAP_MAX gap and a GAP_MAX
  // stall, about 1 ms of sim time; 20 ms leaves wide margin.
  initial begin
    #20ms;
    $display("Some tests failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Calendar predictor
  // ---------------------------------------------------------------------------

  // Gregorian rule: every 4th year, but centuries only when divisible by 400
  function automatic bit leap_year(input int unsigned y);
    return (y % 100 != 0) ? (y % 4 == 0) : (y % 400 == 0);
  endfunction

  function automatic int unsigned year_length(input int unsigned y);
    return leap_year(y) ? 366 : 365;
  endfunction

  // Day count of 1 January of year y
  function automatic int unsigned days_before(input int unsigned y);
    int unsigned sum;
    sum = 0;
    for (int unsigned k = EPOCH_YR; k < y; k++) sum += year_length(k);
    return sum;
  endfunction

  function automatic stamp_t cal(input int y, input int doy, input int mon, input int dom,
                                 input int h, input int mi, input int s, input int msec);
    stamp_t r;
    r.date.year         = YEAR_BITS'(y);
    r.date.day_of_year  = DOY_BITS'(doy);
    r.date.month        = MONTH_BITS'(mon);
    r.date.day_of_month = DOM_BITS'(dom);
    r.tod.hour          = HOUR_BITS'(h);
    r.tod.minute        = MIN_BITS'(mi);
    r.tod.second        = SEC_BITS'(s);
    r.tod.millisecond   = MSEC_BITS'(msec);
    return r;
  endfunction

  function automatic stamp_t to_calendar(input logic [DC_BITS-1:0] d,
                                         input logic [MS_BITS-1:0] ms);
    int unsigned rest, yr, doy, mon, t, hh, mi, ss;
    bit          leap;
    rest = d;
    yr   = EPOCH_YR;
    // peel off whole years
    while (rest >= year_length(yr)) begin
      rest -= year_length(yr);
      yr++;
    end
    doy  = rest + 1;
    leap = leap_year(yr);
    mon  = 1;
    while (doy > (leap ? MONTH_START_LEAP[mon] : MONTH_START_COMMON[mon])) mon++;
    // past the end of the day clamps to the last millisecond
    t  = (ms > LAST_MS) ? LAST_MS : ms;
    hh = t / HOUR_MS;
    t  = t % HOUR_MS;
    mi = t / MINUTE_MS;
    t  = t % MINUTE_MS;
    ss = t / SECOND_MS;
    t  = t % SECOND_MS;
    return cal(yr, doy, mon,
               doy - (leap ? MONTH_START_LEAP[mon-1] : MONTH_START_COMMON[mon-1]),
               hh, mi, ss, t);
  endfunction

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------

  // Drive one timestamp, hold it until the transfer, then log what is owed.
  // Valid stays high into the next call when that call draws no gap.
  task automatic send_stamp(input logic [DC_BITS-1:0] d, input logic [MS_BITS-1:0] ms,
                            input logic fixed, input stamp_t want);
    int gap;
    gap = tx_steady ? 0 : $urandom_range(0, GAP_MAX);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    day_count <= d;
    ms_of_day <= ms;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    // transfer happened at this edge
    pending_stamps.push_back(fixed ? want : to_calendar(d, ms));
  endtask

  task automatic drain_pipe();
    while (pending_stamps.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Output side: random stall ahead of each result
  // ---------------------------------------------------------------------------

  initial begin
    int hold;
    while (rst) @(posedge clk);
    forever begin
      hold = rx_steady ? 0 : $urandom_range(0, GAP_MAX);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  task automatic check_field(input string what, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      mismatches++;
    end
  endtask

  // Every result transfer is matched against the oldest owed result
  always @(posedge clk) begin
    stamp_t owed;
    if (!rst && out_valid && !out_stall) begin
      if (pending_stamps.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %0d-%0d %0d:%0d:%0d.%0d",
                 $time, year, day_of_year, hour, minute, second, millisecond);
        mismatches++;
      end else begin
        owed = pending_stamps.pop_front();
        check_field("year",         owed.date.year,         year);
        check_field("day_of_year",  owed.date.day_of_year,  day_of_year);
        check_field("month",        owed.date.month,        month);
        check_field("day_of_month", owed.date.day_of_month, day_of_month);
        check_field("hour",         owed.tod.hour,          hour);
        check_field("minute",       owed.tod.minute,        minute);
        check_field("second",       owed.tod.second,        second);
        check_field("millisecond",  owed.tod.millisecond,   millisecond);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin
    logic [DC_BITS-1:0] d;
    logic [MS_BITS-1:0] ms;
    int unsigned        y, base, unit, pick, mode;
    int                 d_raw;

    // Directed plan. Typed rows: epoch, end of day, clamped milliseconds,
    // first leap year (1960) around Feb 29 and year end. The remaining rows
    // (2000 leap by the 400 rule, 2100 not leap, top of the day range) go
    // through the predictor.
    plan[0]  = '{0,         0,         1'b1, cal(1958,   1,  1,  1,  0,  0,  0,   0)};
    plan[1]  = '{0,         86399999,  1'b1, cal(1958,   1,  1,  1, 23, 59, 59, 999)};
    plan[2]  = '{0,         86400000,  1'b1, cal(1958,   1,  1,  1, 23, 59, 59, 999)};
    plan[3]  = '{0,         134217727, 1'b1, cal(1958,   1,  1,  1, 23, 59, 59, 999)};
    plan[4]  = '{0,         3599999,   1'b1, cal(1958,   1,  1,  1,  0, 59, 59, 999)};
    plan[5]  = '{0,         3600000,   1'b1, cal(1958,   1,  1,  1,  1,  0,  0,   0)};
    plan[6]  = '{364,       59999,     1'b1, cal(1958, 365, 12, 31,  0,  0, 59, 999)};
    plan[7]  = '{365,       60000,     1'b1, cal(1959,   1,  1,  1,  0,  1,  0,   0)};
    plan[8]  = '{788,       999,       1'b1, cal(1960,  59,  2, 28,  0,  0,  0, 999)};
    plan[9]  = '{789,       1000,      1'b1, cal(1960,  60,  2, 29,  0,  0,  1,   0)};
    plan[10] = '{790,       0,         1'b1, cal(1960,  61,  3,  1,  0,  0,  0,   0)};
    plan[11] = '{1095,      0,         1'b1, cal(1960, 366, 12, 31,  0,  0,  0,   0)};
    plan[12] = '{1096,      0,         1'b1, cal(1961,   1,  1,  1,  0,  0,  0,   0)};
    plan[13] = '{15399,     43200000,  1'b0, '0};
    plan[14] = '{15705,     12345678,  1'b0, '0};
    plan[15] = '{51923,     1,         1'b0, '0};
    plan[16] = '{51924,     86399998,  1'b0, '0};
    plan[17] = '{52229,     7199999,   1'b0, '0};
    plan[18] = '{65535,     134217727, 1'b0, '0};
    plan[19] = '{65535,     0,         1'b0, '0};
    plan[20] = '{32767,     67108864,  1'b0, '0};
    plan[21] = '{32768,     43199999,  1'b0, '0};

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan[r]) send_stamp(plan[r].day, plan[r].ms, plan[r].fixed, plan[r].want);

    // sender holds off until the pipe has handed back everything
    in_valid <= 1'b0;
    @(posedge clk);
    drain_pipe();

    for (int n = 0; n < RAND_ITEMS; n++) begin
      // every 100 items pick a new pacing: random gaps, or steady on either side
      if (n % 100 == 0) begin
        mode      = $urandom_range(0, 3);
        tx_steady = mode[0];
        rx_steady = mode[1];
      end
      if (n == RAND_ITEMS / 2) begin
        in_valid <= 1'b0;
        @(posedge clk);
        drain_pipe();
      end

      // day: mostly anywhere, often hugging year starts, ends and late February
      pick = $urandom_range(0, 9);
      if (pick <= 5) begin
        d_raw = $urandom_range(0, 65535);
      end else if (pick <= 8) begin
        y    = $urandom_range(EPOCH_YR, EPOCH_YR + 179);
        base = days_before(y);
        case ($urandom_range(0, 5))
          0: d_raw = base;
          1: d_raw = base + 58;
          2: d_raw = base + 59;
          3: d_raw = base + 60;
          4: d_raw = base + year_length(y) - 1;
          default: d_raw = base - 1;
        endcase
        if (d_raw < 0) d_raw = 0;
        if (d_raw > 65535) d_raw = 65535;
      end else begin
        d_raw = $urandom_range(0, 1) ? 65535 - $urandom_range(0, 3) : $urandom_range(0, 3);
      end
      d = DC_BITS'(d_raw);

      // time: inside the day, past the day, on unit boundaries, or any 27 bits
      pick = $urandom_range(0, 9);
      if (pick <= 5) begin
        ms = MS_BITS'($urandom_range(0, LAST_MS));
      end else if (pick == 6) begin
        ms = MS_BITS'($urandom_range(LAST_MS + 1, (1 << MS_BITS) - 1));
      end else if (pick <= 8) begin
        case ($urandom_range(0, 2))
          0: unit = SECOND_MS;
          1: unit = MINUTE_MS;
          default: unit = HOUR_MS;
        endcase
        ms = MS_BITS'($urandom_range(1, (LAST_MS + 1) / unit) * unit - $urandom_range(0, 1));
      end else begin
        ms = MS_BITS'($urandom);
      end

      send_stamp(d, ms, 1'b0, '0);
    end

    in_valid <= 1'b0;
    rx_steady = 1'b0;
    @(posedge clk);
    drain_pipe();
    // a few more cycles so a stray extra result would still be caught
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
